// ----- design/sobel_pkg.sv -----
package sobel_pkg;

  localparam int CH_W   = 8;
  localparam int PIX_W  = 3 * CH_W;
  localparam int GRAD_W = 11;
  localparam int ABS_W  = 10;
  localparam int SQ_W   = 2 * ABS_W + 1;

  typedef logic [CH_W-1:0] chan_t;
  typedef logic [PIX_W-1:0] pix_t;
  typedef logic signed [GRAD_W-1:0] grad_t;
  typedef logic [SQ_W-1:0] sq_t;

  // Weighted 1,2,1 sum of one side minus the same of the opposite side
  function automatic grad_t sobel_diff(chan_t a, chan_t b, chan_t c,
                                       chan_t d, chan_t e, chan_t f);
    grad_t pos;
    grad_t neg;
    pos = grad_t'({3'b000, a}) + grad_t'({2'b00, b, 1'b0}) + grad_t'({3'b000, c});
    neg = grad_t'({3'b000, d}) + grad_t'({2'b00, e, 1'b0}) + grad_t'({3'b000, f});
    return pos - neg;
  endfunction

  // Absolute value of a gradient
  function automatic logic [ABS_W-1:0] grad_abs(grad_t g);
    grad_t m;
    m = (g < 0) ? -g : g;
    return m[ABS_W-1:0];
  endfunction

endpackage

// ----- design/sobel_edge_magnitude_rgb.sv -----
// Streaming 3x3 Sobel edge magnitude on RGB pixels in raster order. Each
// transfer on the input channel is a pixel (in_command 0) or a flush
// (in_command 1); results come out one row and one pixel behind the input,
// and flushes drain the tail of the frame. Out-of-image neighbours count
// as zero; each channel gives min(255, floor(sqrt(Gx^2 + Gy^2))). Both line
// stores share one memory of MAX_WIDTH entries, read at the column when a
// transfer is taken and written back the next cycle, so an item that yields
// no result passes through the read state and back to idle. An item that
// yields a result goes on through the squares, the bit-at-a-time square
// root and the load of the output register, which a waiting result may hold
// up; no new item is taken before it is done. Writing width (address 0) or
// height (address 4) restarts the frame; write only while idle.
module sobel_edge_magnitude_rgb
  import sobel_pkg::*;
#(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_command,
  input  logic [7:0]  in_red_in,
  input  logic [7:0]  in_green_in,
  input  logic [7:0]  in_blue_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_red_edge,
  output logic [7:0]  out_green_edge,
  output logic [7:0]  out_blue_edge,
  output logic        out_frame_last,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int RW = $clog2(MAX_HEIGHT + 3);
  localparam int RST_W = (MAX_WIDTH < 1024) ? MAX_WIDTH : 1024;
  localparam int RST_H = (MAX_HEIGHT < 1024) ? MAX_HEIGHT : 1024;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_READ   = 3'd1;
  localparam logic [2:0] ST_SQUARE = 3'd2;
  localparam logic [2:0] ST_ROOT   = 3'd3;
  localparam logic [2:0] ST_DONE   = 3'd4;

  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  logic [2:0]    st_r;
  logic [WW-1:0] width_r;
  logic [HW-1:0] height_r;
  logic [AW-1:0] ic_r;
  logic [RW-1:0] ir_r;
  pix_t          pix_r;
  logic [2*PIX_W-1:0] line_mem [MAX_WIDTH];
  logic [2*PIX_W-1:0] rd_q_r;
  pix_t          win_r [3][3];
  grad_t         gx_r [3];
  grad_t         gy_r [3];
  sq_t           sq_r [3];
  chan_t         rt_r [3];
  logic [7:0]    bit_r;
  logic          last_r;
  logic          out_valid_r;
  chan_t         out_edge_r [3];
  logic          out_last_r;

  logic          cfg_wr;
  logic [10:0]   cfg_v;
  logic          accept;
  pix_t          col_new [3];
  pix_t          v [3][3];
  logic          wrap;
  logic          norm;
  logic          emit;
  logic [RW-1:0] orow;
  logic [WW-1:0] ocol;
  logic          last;
  logic          wr_en;
  logic [AW-1:0] ic_nxt;
  logic [RW-1:0] ir_nxt;

  // Config port
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;
  assign cfg_v  = (pwdata[10:0] == 11'd0) ? 11'd1 : pwdata[10:0];
  assign prdata = (paddr[2] == REG_HEIGHT) ? 32'(height_r) : 32'(width_r);

  assign accept   = in_valid & in_ready;
  assign in_ready = (st_r == ST_IDLE);

  // Build the column entering the window and the window seen by the filter
  assign col_new[0] = rd_q_r[2*PIX_W-1:PIX_W];
  assign col_new[1] = rd_q_r[PIX_W-1:0];
  assign col_new[2] = pix_r;
  assign wrap = (ic_r == '0) && (ir_r >= RW'(2));
  assign norm = (ic_r != '0) && (ir_r >= RW'(1));
  assign emit = wrap | norm;
  assign orow = wrap ? ir_r - RW'(2) : ir_r - RW'(1);
  assign ocol = wrap ? width_r - WW'(1) : WW'(ic_r) - WW'(1);
  assign last = (orow + RW'(1) == RW'(height_r)) && (ocol + WW'(1) == width_r);

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      v[r][0] = win_r[r][1];
      v[r][1] = win_r[r][2];
      v[r][2] = wrap ? '0 : col_new[r];
    end
    for (int k = 0; k < 3; k++) begin
      if (orow == '0) v[0][k] = '0;
      if (orow + RW'(1) == RW'(height_r)) v[2][k] = '0;
      if (ocol == '0) v[k][0] = '0;
      if (ocol + WW'(1) == width_r) v[k][2] = '0;
    end
  end

  // Advance the input position, restart after the frame's last result
  always_comb begin
    ic_nxt = ic_r + AW'(1);
    ir_nxt = ir_r;
    if (32'(ic_r) + 1 >= 32'(width_r)) begin
      ic_nxt = '0;
      if (ir_r != '1) ir_nxt = ir_r + RW'(1);
    end
    if (emit && last) begin
      ic_nxt = '0;
      ir_nxt = '0;
    end
  end

  assign wr_en = (st_r == ST_READ);

  // Line store memory: older and newer rows side by side
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_q_r <= line_mem[ic_r];
    end
    if (wr_en) begin
      line_mem[ic_r] <= {col_new[1], col_new[2]};
    end
  end

  // Control and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      width_r     <= WW'(RST_W);
      height_r    <= HW'(RST_H);
      ic_r        <= '0;
      ir_r        <= '0;
      out_valid_r <= 1'b0;
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          win_r[r][c] <= '0;
        end
      end
    end else begin
      // Load the output register or drop it after its transfer
      if (st_r == ST_DONE && (!out_valid_r || out_ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_wr) begin
        if (paddr[2] == REG_WIDTH) begin
          width_r <= (32'(cfg_v) > MAX_WIDTH) ? WW'(MAX_WIDTH) : WW'(cfg_v);
        end else begin
          height_r <= (32'(cfg_v) > MAX_HEIGHT) ? HW'(MAX_HEIGHT) : HW'(cfg_v);
        end
        ic_r <= '0;
        ir_r <= '0;
      end
      case (st_r)
        ST_IDLE: begin
          if (accept) st_r <= ST_READ;
        end
        ST_READ: begin
          for (int r = 0; r < 3; r++) begin
            win_r[r][0] <= win_r[r][1];
            win_r[r][1] <= win_r[r][2];
            win_r[r][2] <= col_new[r];
          end
          if (!cfg_wr) begin
            ic_r <= ic_nxt;
            ir_r <= ir_nxt;
          end
          st_r <= emit ? ST_SQUARE : ST_IDLE;
        end
        ST_SQUARE: begin
          st_r <= ST_ROOT;
        end
        ST_ROOT: begin
          if (bit_r[0]) st_r <= ST_DONE;
        end
        ST_DONE: begin
          if (!out_valid_r || out_ready) st_r <= ST_IDLE;
        end
        default: st_r <= ST_IDLE;
      endcase
    end
  end

  // Datapath: latch pixel, gradients, squares, root, output
  always_ff @(posedge clk) begin
    if (accept) begin
      pix_r <= (!in_command && (32'(ir_r) < 32'(height_r)))
               ? {in_red_in, in_green_in, in_blue_in} : '0;
    end
    if (st_r == ST_READ) begin
      last_r <= last;
      for (int k = 0; k < 3; k++) begin
        gx_r[k] <= sobel_diff(v[0][2][(2-k)*CH_W +: CH_W], v[1][2][(2-k)*CH_W +: CH_W],
                              v[2][2][(2-k)*CH_W +: CH_W], v[0][0][(2-k)*CH_W +: CH_W],
                              v[1][0][(2-k)*CH_W +: CH_W], v[2][0][(2-k)*CH_W +: CH_W]);
        gy_r[k] <= sobel_diff(v[2][0][(2-k)*CH_W +: CH_W], v[2][1][(2-k)*CH_W +: CH_W],
                              v[2][2][(2-k)*CH_W +: CH_W], v[0][0][(2-k)*CH_W +: CH_W],
                              v[0][1][(2-k)*CH_W +: CH_W], v[0][2][(2-k)*CH_W +: CH_W]);
      end
    end
    if (st_r == ST_SQUARE) begin
      bit_r <= 8'h80;
      for (int k = 0; k < 3; k++) begin
        sq_r[k] <= SQ_W'(grad_abs(gx_r[k])) * SQ_W'(grad_abs(gx_r[k]))
                 + SQ_W'(grad_abs(gy_r[k])) * SQ_W'(grad_abs(gy_r[k]));
        rt_r[k] <= '0;
      end
    end
    if (st_r == ST_ROOT) begin
      bit_r <= bit_r >> 1;
      for (int k = 0; k < 3; k++) begin
        if (SQ_W'(rt_r[k] | bit_r) * SQ_W'(rt_r[k] | bit_r) <= sq_r[k]) begin
          rt_r[k] <= rt_r[k] | bit_r;
        end
      end
    end
    if (st_r == ST_DONE && (!out_valid_r || out_ready)) begin
      out_last_r <= last_r;
      for (int k = 0; k < 3; k++) begin
        out_edge_r[k] <= (sq_r[k] >= SQ_W'(65536)) ? 8'hFF : rt_r[k];
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_red_edge   = out_edge_r[0];
  assign out_green_edge = out_edge_r[1];
  assign out_blue_edge  = out_edge_r[2];
  assign out_frame_last = out_last_r;

`ifndef NO_ASSERTIONS
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_ROOT) |-> !in_ready)
    else $error("input taken while root busy");
  a_restart_last: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_READ && emit && last && !cfg_wr) |=> (ic_r == '0 && ir_r == '0))
    else $error("counters not cleared after frame end");
  a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_IDLE) |-> (32'(ic_r) < 32'(width_r)))
    else $error("column beyond row width");
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> (out_valid_r && $stable(out_edge_r[0])))
    else $error("waiting result overwritten");
`endif

endmodule

// ----- dv/sobel_edge_magnitude_rgb_tb.sv -----
module sobel_edge_magnitude_rgb_tb;
  import sobel_pkg::*;

  localparam logic [2:0] ADDR_WIDTH  = 3'd0;
  localparam logic [2:0] ADDR_HEIGHT = 3'd4;
  localparam bit CMD_PIXEL = 1'b0;
  localparam bit CMD_FLUSH = 1'b1;
  localparam int MAX_W = 1024;
  localparam int MAX_H = 1024;
  localparam int SETTLE_CYCLES = 30;
  localparam int STALL_LIMIT = 5000;
  localparam int RANDOM_ITEMS = 1650;

  typedef struct packed {
    chan_t r;
    chan_t g;
    chan_t b;
    logic  last;
  } edge_res_t;

  typedef enum logic [1:0] {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t   kind;
    bit          cmd;
    chan_t       r, g, b;
    logic [2:0]  addr;
    logic [31:0] data;
    bit          typed;
    edge_res_t   res;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_command = 1'b0;
  logic [7:0]  in_red_in = '0;
  logic [7:0]  in_green_in = '0;
  logic [7:0]  in_blue_in = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_red_edge;
  logic [7:0]  out_green_edge;
  logic [7:0]  out_blue_edge;
  logic        out_frame_last;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  sobel_edge_magnitude_rgb uut (.*);

  // Predictor state
  int   cfg_w = MAX_W;
  int   cfg_h = MAX_H;
  pix_t older_row [MAX_W];
  pix_t newer_row [MAX_W];
  pix_t win [3][3];
  int   in_col, in_row, out_pos;

  edge_res_t edge_q[$];
  int  errors = 0;
  int  snd_idle_pct = 0;
  int  rcv_idle_pct = 0;
  bit  hold_req = 1'b0;
  int  quiet_cycles = 0;

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic int chv(pix_t p, int sh);
    return (p >> sh) & 255;
  endfunction

  // Floor square root of Gx^2 + Gy^2, saturated at 255
  function automatic chan_t grad_mag(pix_t v[3][3], int sh);
    int gx, gy, s, root, t, bt;
    gx = (chv(v[0][2], sh) + 2 * chv(v[1][2], sh) + chv(v[2][2], sh))
       - (chv(v[0][0], sh) + 2 * chv(v[1][0], sh) + chv(v[2][0], sh));
    gy = (chv(v[2][0], sh) + 2 * chv(v[2][1], sh) + chv(v[2][2], sh))
       - (chv(v[0][0], sh) + 2 * chv(v[0][1], sh) + chv(v[0][2], sh));
    s = gx * gx + gy * gy;
    if (s >= 65536) return 8'd255;
    root = 0;
    for (bt = 128; bt != 0; bt = bt >> 1) begin
      t = root | bt;
      if (t * t <= s) root = t;
    end
    return chan_t'(root);
  endfunction

  // Mask neighbors outside the image, then compute all three channels
  function automatic edge_res_t edge_at(pix_t vin[3][3], int orow, int ocol);
    pix_t v[3][3];
    edge_res_t e;
    v = vin;
    for (int k = 0; k < 3; k++) begin
      if (orow == 0) v[0][k] = '0;
      if (orow + 1 == cfg_h) v[2][k] = '0;
      if (ocol == 0) v[k][0] = '0;
      if (ocol + 1 == cfg_w) v[k][2] = '0;
    end
    e.r = grad_mag(v, 16);
    e.g = grad_mag(v, 8);
    e.b = grad_mag(v, 0);
    e.last = (out_pos + 1 == cfg_w * cfg_h);
    return e;
  endfunction

  task automatic edge_predict(input bit cmd, input chan_t r, g, b,
                              output bit got, output edge_res_t res);
    int ic, ir;
    pix_t px;
    pix_t v[3][3];
    ic = in_col;
    ir = in_row;
    px = '0;
    got = 1'b0;
    res = '0;
    if (ic >= cfg_w) ic = 0;
    if (cmd == CMD_PIXEL && ir < cfg_h) px = {r, g, b};
    // row wrap: last column of two rows back
    if (ic == 0 && ir >= 2 && out_pos < cfg_w * cfg_h) begin
      for (int rr = 0; rr < 3; rr++) begin
        v[rr][0] = win[rr][1];
        v[rr][1] = win[rr][2];
        v[rr][2] = '0;
      end
      res = edge_at(v, ir - 2, cfg_w - 1);
      got = 1'b1;
    end
    // advance window and line stores
    for (int rr = 0; rr < 3; rr++) begin
      win[rr][0] = win[rr][1];
      win[rr][1] = win[rr][2];
    end
    win[0][2] = older_row[ic];
    win[1][2] = newer_row[ic];
    win[2][2] = px;
    older_row[ic] = newer_row[ic];
    newer_row[ic] = px;
    if (ic >= 1 && ir >= 1 && out_pos < cfg_w * cfg_h) begin
      res = edge_at(win, ir - 1, ic - 1);
      got = 1'b1;
    end
    if (got) begin
      if (res.last) begin
        in_col = 0;
        in_row = 0;
        out_pos = 0;
        return;
      end
      out_pos++;
    end
    ic++;
    if (ic >= cfg_w) begin
      ic = 0;
      if (ir < 65535) ir++;
    end
    in_col = ic;
    in_row = ir;
  endtask

  // Wait for all results, then let in-flight items settle
  task automatic drain_wait();
    while (edge_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
    int v;
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    v = data & 32'h7FF;
    if (v == 0) v = 1;
    if (addr == ADDR_WIDTH) cfg_w = (v > MAX_W) ? MAX_W : v;
    else cfg_h = (v > MAX_H) ? MAX_H : v;
    in_col = 0;
    in_row = 0;
    out_pos = 0;
  endtask

  // Offer one item, hold it until the transfer, then idle at random
  task automatic send_item(input bit cmd, input chan_t r, g, b,
                           input bit typed, input edge_res_t tres);
    bit got;
    edge_res_t res;
    in_valid <= 1'b1;
    in_command <= cmd;
    in_red_in <= r;
    in_green_in <= g;
    in_blue_in <= b;
    do @(posedge clk); while (!(in_valid && in_ready));
    edge_predict(cmd, r, g, b, got, res);
    if (typed) edge_q.push_back(tres);
    else if (got) edge_q.push_back(res);
    if ($urandom_range(99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      while ($urandom_range(99) < snd_idle_pct) @(posedge clk);
      @(posedge clk);
    end
  endtask

  task automatic send_idle();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Receiver: check each transfer, stall at random, hold off on request
  initial begin
    edge_res_t e;
    int hold_n;
    hold_n = 0;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        if (edge_q.size() == 0) begin
          $error("result with nothing expected");
          errors++;
        end else begin
          e = edge_q.pop_front();
          if (out_red_edge !== e.r) begin
            $error("red_edge expected %0d actual %0d", e.r, out_red_edge);
            errors++;
          end
          if (out_green_edge !== e.g) begin
            $error("green_edge expected %0d actual %0d", e.g, out_green_edge);
            errors++;
          end
          if (out_blue_edge !== e.b) begin
            $error("blue_edge expected %0d actual %0d", e.b, out_blue_edge);
            errors++;
          end
          if (out_frame_last !== e.last) begin
            $error("frame_last expected %0d actual %0d", e.last, out_frame_last);
            errors++;
          end
        end
      end
      if (hold_req && hold_n == 0) begin
        hold_n = 400;
        hold_req = 1'b0;
      end
      if (hold_n > 0) begin
        hold_n--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= rcv_idle_pct);
      end
    end
  end

  // Watchdog on cycles with no transfer
  initial begin
    forever begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("sobel_edge_magnitude_rgb: mismatch");
        $finish;
      end
    end
  end

  initial begin
    stim_row_t rows[$];
    stim_row_t row;
    edge_res_t none;
    int total, phase, w, h, n, cnt;
    bit cmd;
    none = '0;
    for (int i = 0; i < MAX_W; i++) begin
      older_row[i] = '0;
      newer_row[i] = '0;
    end
    for (int i = 0; i < 9; i++) win[i / 3][i % 3] = '0;
    in_col = 0;
    in_row = 0;
    out_pos = 0;

    // Directed table: reset size, single pixel frame, 3x3 extremes,
    // early flush, late pixel, out-of-range register values
    rows.push_back('{ROW_ITEM, CMD_PIXEL, 8'h00, 8'h00, 8'h00, 0, 0, 0, none});
    rows.push_back('{ROW_ITEM, CMD_PIXEL, 8'hFF, 8'hFF, 8'hFF, 0, 0, 0, none});
    rows.push_back('{ROW_ITEM, CMD_FLUSH, 8'hFF, 8'h00, 8'hFF, 0, 0, 0, none});
    rows.push_back('{ROW_CFG, CMD_PIXEL, 0, 0, 0, ADDR_WIDTH, 32'd1, 0, none});
    rows.push_back('{ROW_CFG, CMD_PIXEL, 0, 0, 0, ADDR_HEIGHT, 32'd1, 0, none});
    rows.push_back('{ROW_ITEM, CMD_PIXEL, 8'hFF, 8'hFF, 8'hFF, 0, 0, 0, none});
    rows.push_back('{ROW_ITEM, CMD_FLUSH, 8'h00, 8'h00, 8'h00, 0, 0, 0, none});
    rows.push_back('{ROW_ITEM, CMD_FLUSH, 8'h00, 8'h00, 8'h00, 1, 0, 0,
                     edge_res_t'{8'd0, 8'd0, 8'd0, 1'b1}});
    rows.push_back('{ROW_CFG, CMD_PIXEL, 0, 0, 0, ADDR_WIDTH, 32'd3, 0, none});
    rows.push_back('{ROW_CFG, CMD_PIXEL, 0, 0, 0, ADDR_HEIGHT, 32'd3, 0, none});
    for (int i = 0; i < 9; i++) begin
      row = '{ROW_ITEM, CMD_PIXEL, (i % 2) ? 8'hFF : 8'h00, (i % 3) ? 8'h00 : 8'hFF,
              (i > 4) ? 8'hFF : 8'h00, 0, 0, 0, none};
      if (i == 4) row.cmd = CMD_FLUSH;
      rows.push_back(row);
    end
    for (int i = 0; i < 3; i++)
      rows.push_back('{ROW_ITEM, CMD_FLUSH, 8'h00, 8'h00, 8'h00, 0, 0, 0, none});
    rows.push_back('{ROW_ITEM, CMD_PIXEL, 8'hFF, 8'hFF, 8'hFF, 0, 0, 0, none});
    rows.push_back('{ROW_CFG, CMD_PIXEL, 0, 0, 0, ADDR_WIDTH, 32'd0, 0, none});
    rows.push_back('{ROW_CFG, CMD_PIXEL, 0, 0, 0, ADDR_HEIGHT, 32'h7FF, 0, none});
    rows.push_back('{ROW_ITEM, CMD_PIXEL, 8'h80, 8'h7F, 8'h01, 0, 0, 0, none});
    rows.push_back('{ROW_ITEM, CMD_PIXEL, 8'hFE, 8'h40, 8'h02, 0, 0, 0, none});
    rows.push_back('{ROW_CFG, CMD_PIXEL, 0, 0, 0, ADDR_WIDTH, 32'h7FF, 0, none});
    rows.push_back('{ROW_CFG, CMD_PIXEL, 0, 0, 0, ADDR_HEIGHT, 32'd0, 0, none});
    rows.push_back('{ROW_ITEM, CMD_PIXEL, 8'h55, 8'hAA, 8'h10, 0, 0, 0, none});
    rows.push_back('{ROW_ITEM, CMD_FLUSH, 8'h00, 8'h00, 8'h00, 0, 0, 0, none});

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i]) begin
      if (rows[i].kind == ROW_CFG) begin
        in_valid <= 1'b0;
        drain_wait();
        reg_write(rows[i].addr, rows[i].data);
      end else begin
        send_item(rows[i].cmd, rows[i].r, rows[i].g, rows[i].b, rows[i].typed,
                  rows[i].res);
      end
    end

    // Random frames, mostly small, with broken sequences mixed in
    total = 0;
    phase = 0;
    while (total < RANDOM_ITEMS) begin
      if (total < RANDOM_ITEMS / 3) begin
        snd_idle_pct = 23;
        rcv_idle_pct = 65;
      end else if (total < 2 * RANDOM_ITEMS / 3) begin
        snd_idle_pct = 65;
        rcv_idle_pct = 23;
      end else begin
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
      end
      w = ($urandom_range(7) == 0) ? $urandom_range(9, 64) : $urandom_range(1, 8);
      h = $urandom_range(1, 6);
      in_valid <= 1'b0;
      drain_wait();
      reg_write(ADDR_WIDTH, w);
      reg_write(ADDR_HEIGHT, h);
      if (phase == 3) hold_req = 1'b1;
      cnt = $urandom_range(1, 2);
      n = cnt * (w * h + w + 1);
      for (int i = 0; i < n; i++) begin
        cmd = ((i % (w * h + w + 1)) < w * h) ? CMD_PIXEL : CMD_FLUSH;
        if ($urandom_range(19) == 0) cmd = ~cmd;
        send_item(cmd, chan_t'($urandom), chan_t'($urandom), chan_t'($urandom), 0, none);
        if ($urandom_range(99) < snd_idle_pct && $urandom_range(3) == 0) send_idle();
      end
      total += n;
      phase++;
    end
    in_valid <= 1'b0;

    while (edge_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("sobel_edge_magnitude_rgb: match");
    end else begin
      $display("sobel_edge_magnitude_rgb: mismatch");
    end
    $finish;
  end

endmodule

// ----- files.f -----
design/sobel_pkg.sv
design/sobel_edge_magnitude_rgb.sv
dv/sobel_edge_magnitude_rgb_tb.sv
